[rtl/free_list_fit_allocator_defines.svh]
// assertion macros for the free list allocator checker
`ifndef FREE_LIST_FIT_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FLFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define FLFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[rtl/flfa_pkg.sv]
// ----------------------------------------------------------------------------
// flfa_pkg
// shared constants and types of the free list allocator
// ----------------------------------------------------------------------------
package flfa_pkg;

   localparam int HEAP_SIZE = 128;
   localparam int IDX_W     = $clog2(HEAP_SIZE);
   localparam int LEN_W     = $clog2(HEAP_SIZE + 1);

   localparam logic [2:0] MODE_FIRST = 3'd0;
   localparam logic [2:0] MODE_BEST  = 3'd1;
   localparam logic [2:0] MODE_WORST = 3'd2;
   localparam logic [2:0] MODE_NEXT  = 3'd3;
   localparam logic [2:0] MODE_FREE  = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   localparam logic [2:0] OP_HOLD   = 3'd0;
   localparam logic [2:0] OP_ROTATE = 3'd1;
   localparam logic [2:0] OP_TAKE   = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_LOAD   = 3'd4;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [IDX_W-1:0] start;
      logic [LEN_W-1:0] len;
   } extent_type;

   typedef struct packed {
      logic [2:0]       op;
      logic [IDX_W-1:0] sel;
      logic [IDX_W-1:0] start;
      logic [LEN_W-1:0] len;
   } cell_ctl_type;

endpackage

[rtl/flfa_cell.sv]
// ----------------------------------------------------------------------------
// flfa_cell
// one free list entry; rotates, shifts down, shrinks or loads
// ----------------------------------------------------------------------------
module flfa_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  flfa_pkg::idx_type    cell_index,
   input  flfa_pkg::cell_ctl_type ctl,
   input  flfa_pkg::extent_type nbr,
   output flfa_pkg::extent_type ext
);
   import flfa_pkg::*;

   extent_type ext_ff, ext_in;

   always_comb begin
      ext_in = ext_ff;
      unique case (ctl.op)
         OP_ROTATE: ext_in = nbr;
         OP_TAKE: begin
            if (cell_index == ctl.sel) begin
               ext_in.start = ext_ff.start + ctl.len[IDX_W-1:0];
               ext_in.len   = ext_ff.len - ctl.len;
            end
         end
         OP_REMOVE: begin
            if (cell_index >= ctl.sel) ext_in = nbr;
         end
         OP_LOAD: begin
            if (cell_index == ctl.sel) begin
               ext_in.start = ctl.start;
               ext_in.len   = ctl.len;
            end
         end
         default: ext_in = ext_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff.start <= '0;
         ext_ff.len   <= (cell_index == '0) ? LEN_W'(HEAP_SIZE) : '0;
      end else begin
         ext_ff <= ext_in;
      end
   end

   assign ext = ext_ff;

endmodule

[rtl/free_list_fit_allocator.sv]
// ----------------------------------------------------------------------------
// free_list_fit_allocator
// heap allocator with a free list held in a ring of extent cells
// ----------------------------------------------------------------------------
// a bad request or a free is answered straight from idle; an allocate first scans one full
// rotation of the cell ring (S_SCAN), then S_DECIDE, then S_REMOVE when the extent empties
// throughput: one transaction at a time, next accepted once the result is taken
// reset: list holds one extent covering the heap, count 1, roving index 0
module free_list_fit_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_mode,
   input  logic [flfa_pkg::LEN_W-1:0]  req_length,
   input  logic [flfa_pkg::IDX_W-1:0]  req_free_start,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [flfa_pkg::IDX_W-1:0]  rsp_granted_start,
   output logic [flfa_pkg::LEN_W-1:0]  rsp_extent_count
);
   import flfa_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;
   localparam logic [1:0] S_REMOVE = 2'd3;

   extent_type   ext_q [HEAP_SIZE];
   cell_ctl_type ctl;

   logic [1:0]       state_ff, state_in;
   logic [2:0]       mode_ff, mode_in;
   logic [LEN_W-1:0] rlen_ff, rlen_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] rov_ff, rov_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic             pf_ff, pf_in, hf_ff, hf_in;
   extent_type       pe_ff, pe_in, he_ff, he_in;
   logic [IDX_W-1:0] pi_ff, pi_in, hi_ff, hi_in, sel_ff, sel_in;
   logic             rv_ff, rv_in;
   logic [1:0]       rs_ff, rs_in;
   logic [IDX_W-1:0] rg_ff, rg_in;
   logic [LEN_W-1:0] rc_ff, rc_in;

   genvar k;
   generate
      for (k = 0; k < HEAP_SIZE; k++) begin : g_cell
         flfa_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (IDX_W'(k)),
            .ctl        (ctl),
            .nbr        (ext_q[(k + 1) % HEAP_SIZE]),
            .ext        (ext_q[k])
         );
      end
   endgenerate

   logic             head_fit, take_hi, chosen;
   logic [IDX_W-1:0] ch_idx;
   extent_type       ch_ext;

   always_comb begin
      head_fit = ({1'b0, cnt_ff} < total_ff) && (ext_q[0].len >= rlen_ff);
      take_hi  = (mode_ff == MODE_NEXT) && hf_ff;
      chosen   = take_hi ? hf_ff : pf_ff;
      ch_idx   = take_hi ? hi_ff : pi_ff;
      ch_ext   = take_hi ? he_ff : pe_ff;
   end

   always_comb begin
      state_in = state_ff;  mode_in = mode_ff;  rlen_in = rlen_ff;
      cnt_in = cnt_ff;  total_in = total_ff;  rov_in = rov_ff;  base_in = base_ff;
      pf_in = pf_ff;  pe_in = pe_ff;  pi_in = pi_ff;
      hf_in = hf_ff;  he_in = he_ff;  hi_in = hi_ff;  sel_in = sel_ff;
      rv_in = rv_ff;  rs_in = rs_ff;  rg_in = rg_ff;  rc_in = rc_ff;
      ctl = '{op: OP_HOLD, sel: '0, start: '0, len: '0};
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      req_ready = (state_ff == S_IDLE) && !rv_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rg_in = '0;
               rc_in = total_ff;
               if (req_mode > MODE_FREE || req_length == '0) begin
                  rv_in = 1'b1;  rs_in = ST_BAD;
               end else if (req_mode == MODE_FREE) begin
                  rv_in = 1'b1;
                  if (({2'b00, req_free_start} + {1'b0, req_length}) > (LEN_W + 1)'(HEAP_SIZE)
                      || total_ff >= LEN_W'(HEAP_SIZE)) begin
                     rs_in = ST_BAD;
                  end else begin
                     rs_in = ST_DONE;
                     ctl = '{op: OP_LOAD, sel: total_ff[IDX_W-1:0],
                             start: req_free_start, len: req_length};
                     total_in = total_ff + 1'b1;
                     rc_in = total_ff + 1'b1;
                  end
               end else begin
                  mode_in = req_mode;  rlen_in = req_length;
                  cnt_in = '0;  pf_in = 1'b0;  hf_in = 1'b0;
                  base_in = ({1'b0, rov_ff} < total_ff) ? rov_ff : '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            ctl.op = OP_ROTATE;
            if (head_fit) begin
               priority if (mode_ff == MODE_BEST) begin
                  if (!pf_ff || ext_q[0].len < pe_ff.len) begin
                     pf_in = 1'b1;  pe_in = ext_q[0];  pi_in = cnt_ff;
                  end
               end else if (mode_ff == MODE_WORST) begin
                  if (!pf_ff || ext_q[0].len > pe_ff.len) begin
                     pf_in = 1'b1;  pe_in = ext_q[0];  pi_in = cnt_ff;
                  end
               end else begin
                  if (!pf_ff) begin
                     pf_in = 1'b1;  pe_in = ext_q[0];  pi_in = cnt_ff;
                  end
                  if (!hf_ff && cnt_ff >= base_ff) begin
                     hf_in = 1'b1;  he_in = ext_q[0];  hi_in = cnt_ff;
                  end
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(HEAP_SIZE - 1)) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            rg_in = '0;
            rc_in = total_ff;
            if (!chosen) begin
               rv_in = 1'b1;  rs_in = ST_NOFIT;  state_in = S_IDLE;
            end else begin
               ctl = '{op: OP_TAKE, sel: ch_idx, start: '0, len: rlen_ff};
               rg_in = ch_ext.start;
               rs_in = ST_DONE;
               sel_in = ch_idx;
               if (mode_ff == MODE_NEXT) rov_in = ch_idx;
               if (ch_ext.len == rlen_ff) begin
                  state_in = S_REMOVE;
               end else begin
                  rv_in = 1'b1;  state_in = S_IDLE;
               end
            end
         end
         S_REMOVE: begin
            ctl = '{op: OP_REMOVE, sel: sel_ff, start: '0, len: '0};
            total_in = total_ff - 1'b1;
            rc_in = total_ff - 1'b1;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= LEN_W'(1);
         rov_ff   <= '0;
         rv_ff    <= 1'b0;
         cnt_ff   <= '0;
         pf_ff    <= 1'b0;
         hf_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         rov_ff   <= rov_in;
         rv_ff    <= rv_in;
         cnt_ff   <= cnt_in;
         pf_ff    <= pf_in;
         hf_ff    <= hf_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;  rlen_ff <= rlen_in;  base_ff <= base_in;
      pe_ff <= pe_in;  pi_ff <= pi_in;  he_ff <= he_in;  hi_ff <= hi_in;
      sel_ff <= sel_in;  rs_ff <= rs_in;  rg_ff <= rg_in;  rc_ff <= rc_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = rs_ff;
   assign rsp_granted_start = rg_ff;
   assign rsp_extent_count  = rc_ff;

endmodule

[rtl/flfa_checker.sv]
// ----------------------------------------------------------------------------
// flfa_checker
// port level checks of the free list allocator
// ----------------------------------------------------------------------------
`include "free_list_fit_allocator_defines.svh"

module flfa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic [flfa_pkg::IDX_W-1:0]  rsp_granted_start,
   input logic [flfa_pkg::LEN_W-1:0]  rsp_extent_count
);
   import flfa_pkg::*;

   `FLFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_granted_start))
   `FLFA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `FLFA_ASSERT_NOW(a_grant_zero, clock, reset, rsp_valid && rsp_status != ST_DONE,
      rsp_granted_start == '0)
   `FLFA_ASSERT_NOW(a_count_range, clock, reset, rsp_valid,
      rsp_extent_count <= LEN_W'(HEAP_SIZE) && rsp_status <= ST_BAD)

endmodule

bind free_list_fit_allocator flfa_checker u_flfa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_granted_start (rsp_granted_start),
   .rsp_extent_count  (rsp_extent_count)
);

[verif/free_list_fit_allocator_test.sv]
// ----------------------------------------------------------------------------
// free_list_fit_allocator_test
// drives allocate and free transactions into the allocator, predicts every
// result from a local copy of the free list, and checks each response field
// by field under several idle and stall patterns
// ----------------------------------------------------------------------------
module free_list_fit_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import flfa_pkg::*;

   typedef struct {
      logic [1:0]       status;
      logic [IDX_W-1:0] granted;
      logic [LEN_W-1:0] count;
   } alloc_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_mode = MODE_FIRST;
   logic [LEN_W-1:0] req_length = '0;
   logic [IDX_W-1:0] req_free_start = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_status;
   logic [IDX_W-1:0] rsp_granted_start;
   logic [LEN_W-1:0] rsp_extent_count;

   free_list_fit_allocator uut (.*);

   always #4 clock = ~clock;

   // local model of the heap
   int unsigned ext_start_m [HEAP_SIZE];
   int unsigned ext_len_m [HEAP_SIZE];
   int unsigned ext_total_m;
   int unsigned rover_m;
   alloc_result_type pending_results [$];

   int errors = 0;
   int sent = 0;
   int checked = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   longint cycle = 0;

   function automatic int unsigned pick_extent(int unsigned mode, int unsigned len);
      int unsigned pick;
      int unsigned base;
      int unsigned i;
      pick = ext_total_m;
      if (mode == MODE_FIRST) begin
         for (i = 0; i < ext_total_m; i++) if (ext_len_m[i] >= len) return i;
      end else if (mode == MODE_BEST || mode == MODE_WORST) begin
         for (i = 0; i < ext_total_m; i++)
            if (ext_len_m[i] >= len && (pick == ext_total_m ||
                (mode == MODE_BEST ? ext_len_m[i] < ext_len_m[pick]
                                   : ext_len_m[i] > ext_len_m[pick])))
               pick = i;
      end else begin
         base = (rover_m < ext_total_m) ? rover_m : 0;
         for (int unsigned n = 0; n < ext_total_m; n++) begin
            i = base + n;
            if (i >= ext_total_m) i -= ext_total_m;
            if (ext_len_m[i] >= len) return i;
         end
      end
      return pick;
   endfunction

   function automatic alloc_result_type predict_alloc(int unsigned mode, int unsigned len,
                                                      int unsigned fs);
      alloc_result_type r;
      int unsigned idx;
      r.status = ST_DONE;
      r.granted = '0;
      if (mode > MODE_FREE || len == 0) begin
         r.status = ST_BAD;
      end else if (mode == MODE_FREE) begin
         if (fs + len > HEAP_SIZE || ext_total_m >= HEAP_SIZE) begin
            r.status = ST_BAD;
         end else begin
            ext_start_m[ext_total_m] = fs;
            ext_len_m[ext_total_m] = len;
            ext_total_m++;
         end
      end else begin
         idx = pick_extent(mode, len);
         if (idx >= ext_total_m) begin
            r.status = ST_NOFIT;
         end else begin
            r.granted = IDX_W'(ext_start_m[idx]);
            ext_start_m[idx] += len;
            ext_len_m[idx] -= len;
            if (ext_len_m[idx] == 0) begin
               for (int unsigned k = idx; k + 1 < ext_total_m; k++) begin
                  ext_start_m[k] = ext_start_m[k+1];
                  ext_len_m[k] = ext_len_m[k+1];
               end
               ext_total_m--;
            end
            if (mode == MODE_NEXT) rover_m = idx;
         end
      end
      r.count = LEN_W'(ext_total_m);
      return r;
   endfunction

   task automatic send_request(int unsigned mode, int unsigned len, int unsigned fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= 3'(mode);
      req_length <= LEN_W'(len);
      req_free_start <= IDX_W'(fs);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_alloc(mode, len, fs));
      sent++;
      @(negedge clock);
   endtask

   // receiver side
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      alloc_result_type e;
      cycle++;
      if (cycle > 3000000) begin
         $display("free_list_fit_allocator_test NOT OK");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            e = pending_results.pop_front();
            checked++;
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_granted_start !== e.granted) begin
               $error("granted_start expected %0d actual %0d", e.granted, rsp_granted_start);
               errors++;
            end
            if (rsp_extent_count !== e.count) begin
               $error("extent_count expected %0d actual %0d", e.count, rsp_extent_count);
               errors++;
            end
         end
      end
   end

   task automatic drain;
      req_valid <= 0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed;
      send_request(MODE_FIRST, 0, 0);
      send_request(5, 4, 0);
      send_request(6, 4, 0);
      send_request(7, 255, 127);
      send_request(MODE_FREE, 0, 3);
      send_request(MODE_FIRST, 129, 0);
      send_request(MODE_FIRST, 255, 0);
      send_request(MODE_FREE, 2, 127);
      send_request(MODE_FREE, 128, 1);
      send_request(MODE_FIRST, 128, 0);
      send_request(MODE_BEST, 1, 0);
      send_request(MODE_NEXT, 1, 0);
      send_request(MODE_FREE, 10, 0);
      send_request(MODE_FREE, 20, 40);
      send_request(MODE_FREE, 10, 100);
      send_request(MODE_BEST, 5, 0);
      send_request(MODE_WORST, 5, 0);
      send_request(MODE_NEXT, 5, 0);
      send_request(MODE_NEXT, 15, 0);
      send_request(MODE_NEXT, 3, 0);
      send_request(MODE_FREE, 1, 127);
      send_request(MODE_FREE, 128, 0);
      send_request(MODE_WORST, 128, 0);
      drain();
   endtask

   task automatic random_request;
      int unsigned r;
      int unsigned len;
      r = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 24);
      if (r < 4) send_request($urandom_range(7), $urandom_range(255), $urandom_range(127));
      else if (r < 50) begin
         len = (len == 0) ? 1 : len;
         send_request(MODE_FREE, len % 129, $urandom_range(128 - (len % 129)));
      end else send_request($urandom_range(MODE_FIRST, MODE_NEXT), len, $urandom_range(127));
   endtask

   task automatic test_random_phase(int idle, int stall, int n);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (n) random_request();
      drain();
   endtask

   task automatic test_long_hold;
      hold_cycles = 600;
      repeat (6) random_request();
      drain();
   endtask

   // fill the list toward its limit with one-unit frees
   task automatic test_full_list;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (130) send_request(MODE_FREE, 1, $urandom_range(127));
      send_request(MODE_FREE, 1, 0);
      send_request(MODE_FIRST, 1, 0);
      drain();
   endtask

   initial begin
      for (int i = 0; i < HEAP_SIZE; i++) begin
         ext_start_m[i] = 0;
         ext_len_m[i] = 0;
      end
      ext_len_m[0] = HEAP_SIZE;
      ext_total_m = 1;
      rover_m = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_random_phase(0, 0, 75);
      test_random_phase(47, 0, 75);
      test_random_phase(0, 47, 75);
      test_random_phase(23, 23, 75);
      test_long_hold();
      test_full_list();
      repeat (300) @(posedge clock);
      $display("ran %0d transactions, %0d responses checked: all fit modes, frees,", sent,
               checked);
      $display("bad requests, full list, idle and stall phases and a long receiver hold");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("free_list_fit_allocator_test OK");
      end else begin
         $display("free_list_fit_allocator_test NOT OK");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/flfa_pkg.sv
rtl/flfa_cell.sv
rtl/free_list_fit_allocator.sv
rtl/flfa_checker.sv
verif/free_list_fit_allocator_test.sv
